FILE: sv/dsp_pkg.sv
// Types and constants shared by the shortest path engine and its checker.
package dsp_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VIDX_W       = 5;
    localparam int VCNT_W       = VIDX_W + 1;
    localparam int EIDX_W       = 2 * VIDX_W;
    localparam int DIST_W       = 21;

    localparam logic [DIST_W-1:0] DIST_MAX     = '1;
    localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(MAX_VERTICES);

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_RUN    = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_REJECT   = 3'd2;
    localparam logic [2:0] ST_REPORT   = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [VIDX_W-1:0] vertex_a;
        logic [VIDX_W-1:0] vertex_b;
        logic [15:0]       edge_weight;
        logic [VIDX_W-1:0] source_vertex;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [VIDX_W-1:0] vertex_index;
        logic [DIST_W-1:0] distance;
        logic              reached;
        logic              last;
    } t_res;

endpackage

FILE: sv/dijkstra_shortest_paths.sv
// Undirected weighted graph store with a single-source shortest path engine.
//
// A request is taken when i_start is high and o_busy is low. Clear and
// rejected requests give one result, strobed on o_res_valid, on the cycle
// after their transfer; an add answers through the result register from
// S_ADD_CHK when the pair is already present and from S_ADD_B when it stores
// the edge. A run from source holds o_busy through its rounds, with n the active
// vertex count: each round scans the distance memory through its single read
// port, then relaxes the chosen vertex's row through the same port, one vertex
// per cycle. The n distance reports then come one per cycle, the final one
// flagged by last and shown in the first cycle in which o_busy is low. The
// receiver cannot stall: each result is on the ports for exactly one cycle.
// The vertex count register is written through i_cfg_valid/o_cfg_ready while
// the block is idle.
module dijkstra_shortest_paths
    import dsp_pkg::*;
#(
    parameter int WEIGHT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_req              i_req,
    output logic              o_res_valid,
    output t_res              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [VCNT_W-1:0] i_cfg_data
);

    localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ADD_CHK = 7'b0000010,
        S_ADD_B   = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_SEL     = 7'b0010000,
        S_RELAX   = 7'b0100000,
        S_REP     = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic [VCNT_W-1:0]        r_vcount, n_vcount;
    t_req                     r_req, n_req;
    logic [MAX_VERTICES-1:0]  r_row_valid, n_row_valid;
    logic [MAX_VERTICES-1:0]  r_finite, n_finite;
    logic [MAX_VERTICES-1:0]  r_done, n_done;
    logic [VCNT_W-1:0]        r_idx, n_idx;
    logic [VIDX_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic                     r_cmp_vld, n_cmp_vld;
    logic                     r_found, n_found;
    logic [DIST_W-1:0]        r_best, n_best;
    logic [VIDX_W-1:0]        r_u, n_u;
    logic                     r_res_valid, n_res_valid;
    t_res                     r_res, n_res;

    // adjacency rows, edge weights, tentative distances
    logic [MAX_VERTICES-1:0]  r_row_mem  [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0]   r_wgt_mem  [MAX_VERTICES*MAX_VERTICES];
    logic [DIST_W-1:0]        r_dist_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  r_row_q;
    logic                     r_rowv_q;
    logic [WEIGHT_BITS-1:0]   r_wgt_q;
    logic [DIST_W-1:0]        r_dist_q;

    logic                     row_rd_en, row_we;
    logic [VIDX_W-1:0]        row_rd_addr, row_wr_addr;
    logic [MAX_VERTICES-1:0]  row_wr_data;
    logic                     wgt_we;
    logic [EIDX_W-1:0]        wgt_wr_addr, wgt_rd_addr;
    logic [WEIGHT_BITS-1:0]   wgt_wr_data;
    logic                     dist_we;
    logic [VIDX_W-1:0]        dist_wr_addr, dist_rd_addr;
    logic [DIST_W-1:0]        dist_wr_data;

    logic [VCNT_W-1:0]        act_n;
    logic                     accept;
    logic                     issue;
    logic                     cmp_last;
    logic                     cand;
    logic                     upd;
    logic [SUM_W-1:0]         sum;
    logic [DIST_W-1:0]        nd;
    logic [MAX_VERTICES-1:0]  row_base;
    logic [MAX_VERTICES-1:0]  one;
    logic [WEIGHT_BITS-1:0]   w_in;

    assign act_n    = (r_vcount > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vcount;
    assign accept   = i_start && (r_state == S_IDLE);
    assign issue    = (r_idx < act_n);
    assign cmp_last = r_cmp_vld && (r_idx == act_n);
    assign one      = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    assign row_base = r_rowv_q ? r_row_q : '0;
    assign w_in     = WEIGHT_BITS'(r_req.edge_weight);

    assign dist_rd_addr = r_idx[VIDX_W-1:0];
    assign wgt_rd_addr  = {r_u, r_idx[VIDX_W-1:0]};

    assign cand = r_cmp_vld && !r_done[r_cmp_idx] && r_finite[r_cmp_idx]
                  && (!r_found || (r_dist_q < r_best));

    // saturating relaxation of one neighbor
    assign sum = SUM_W'(r_best) + SUM_W'(r_wgt_q);
    assign nd  = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    assign upd = r_cmp_vld && r_rowv_q && r_row_q[r_cmp_idx] && !r_done[r_cmp_idx]
                 && (!r_finite[r_cmp_idx] || (nd < r_dist_q));

    always_comb begin
        n_state     = r_state;
        n_vcount    = r_vcount;
        n_req       = r_req;
        n_row_valid = r_row_valid;
        n_finite    = r_finite;
        n_done      = r_done;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_found     = r_found;
        n_best      = r_best;
        n_u         = r_u;
        n_res_valid = 1'b0;
        n_res       = r_res;

        row_rd_en    = 1'b0;
        row_rd_addr  = r_req.vertex_a;
        row_we       = 1'b0;
        row_wr_addr  = r_req.vertex_a;
        row_wr_data  = row_base;
        wgt_we       = 1'b0;
        wgt_wr_addr  = {r_req.vertex_a, r_req.vertex_b};
        wgt_wr_data  = w_in;
        dist_we      = 1'b0;
        dist_wr_addr = r_cmp_idx;
        dist_wr_data = nd;

        // scan, relax and report share the read issue pipeline
        if ((r_state == S_SCAN) || (r_state == S_RELAX) || (r_state == S_REP)) begin
            if (issue) begin
                n_idx     = r_idx + VCNT_W'(1);
                n_cmp_idx = r_idx[VIDX_W-1:0];
                n_cmp_vld = 1'b1;
            end else begin
                n_cmp_vld = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_vcount = i_cfg_data;
                end
                if (accept) begin
                    n_req       = i_req;
                    n_res       = '0;
                    n_res.last  = 1'b1;
                    case (i_req.req_type)
                        REQ_ADD: begin
                            if (({1'b0, i_req.vertex_a} >= act_n)
                                || ({1'b0, i_req.vertex_b} >= act_n)
                                || (i_req.vertex_a == i_req.vertex_b)) begin
                                n_res_valid = 1'b1;
                                n_res.status = ST_REJECT;
                            end else begin
                                row_rd_en   = 1'b1;
                                row_rd_addr = i_req.vertex_a;
                                n_state     = S_ADD_CHK;
                            end
                        end
                        REQ_CLEAR: begin
                            n_row_valid  = '0;
                            n_res_valid  = 1'b1;
                            n_res.status = ST_CLEARED;
                        end
                        REQ_RUN: begin
                            if ({1'b0, i_req.source_vertex} >= act_n) begin
                                n_res_valid  = 1'b1;
                                n_res.status = ST_REJECT;
                            end else begin
                                n_finite     = one << i_req.source_vertex;
                                n_done       = '0;
                                dist_we      = 1'b1;
                                dist_wr_addr = i_req.source_vertex;
                                dist_wr_data = '0;
                                n_idx        = '0;
                                n_cmp_vld    = 1'b0;
                                n_found      = 1'b0;
                                n_state      = S_SCAN;
                            end
                        end
                        default: begin
                            n_res_valid  = 1'b1;
                            n_res.status = ST_REJECT;
                        end
                    endcase
                end
            end
            S_ADD_CHK: begin
                if (r_rowv_q && r_row_q[r_req.vertex_b]) begin
                    n_res_valid  = 1'b1;
                    n_res.status = ST_DUP;
                    n_state      = S_IDLE;
                end else begin
                    row_we      = 1'b1;
                    row_wr_addr = r_req.vertex_a;
                    row_wr_data = row_base | (one << r_req.vertex_b);
                    n_row_valid[r_req.vertex_a] = 1'b1;
                    wgt_we      = 1'b1;
                    wgt_wr_addr = {r_req.vertex_a, r_req.vertex_b};
                    row_rd_en   = 1'b1;
                    row_rd_addr = r_req.vertex_b;
                    n_state     = S_ADD_B;
                end
            end
            S_ADD_B: begin
                row_we      = 1'b1;
                row_wr_addr = r_req.vertex_b;
                row_wr_data = row_base | (one << r_req.vertex_a);
                n_row_valid[r_req.vertex_b] = 1'b1;
                wgt_we      = 1'b1;
                wgt_wr_addr = {r_req.vertex_b, r_req.vertex_a};
                n_res_valid  = 1'b1;
                n_res.status = ST_ADDED;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                if (cand) begin
                    n_found = 1'b1;
                    n_best  = r_dist_q;
                    n_u     = r_cmp_idx;
                end
                if (cmp_last) begin
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = (r_found || cand) ? S_SEL : S_REP;
                end
            end
            S_SEL: begin
                n_done[r_u] = 1'b1;
                row_rd_en   = 1'b1;
                row_rd_addr = r_u;
                n_state     = S_RELAX;
            end
            S_RELAX: begin
                if (upd) begin
                    dist_we              = 1'b1;
                    n_finite[r_cmp_idx]  = 1'b1;
                end
                if (cmp_last) begin
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_found   = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_REP: begin
                if (r_cmp_vld) begin
                    n_res_valid        = 1'b1;
                    n_res.status       = ST_REPORT;
                    n_res.vertex_index = r_cmp_idx;
                    n_res.distance     = r_finite[r_cmp_idx] ? r_dist_q : '0;
                    n_res.reached      = r_finite[r_cmp_idx];
                    n_res.last         = cmp_last;
                end
                if (cmp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= VCOUNT_RESET;
            r_row_valid <= '0;
            r_finite    <= '0;
            r_done      <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcount    <= n_vcount;
            r_row_valid <= n_row_valid;
            r_finite    <= n_finite;
            r_done      <= n_done;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_cmp_idx <= n_cmp_idx;
        r_best    <= n_best;
        r_u       <= n_u;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_wr_addr] <= row_wr_data;
        end
        if (row_rd_en) begin
            r_row_q  <= r_row_mem[row_rd_addr];
            r_rowv_q <= r_row_valid[row_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wgt_we) begin
            r_wgt_mem[wgt_wr_addr] <= wgt_wr_data;
        end
        r_wgt_q <= r_wgt_mem[wgt_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_wr_addr] <= dist_wr_data;
        end
        r_dist_q <= r_dist_mem[dist_rd_addr];
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: sv/dsp_checker.sv
// Port-level checks for the shortest path engine, bound to its top level.
module dsp_checker
    import dsp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input t_req i_req,
    input logic o_res_valid,
    input t_res o_res
);

    // a report that is not the final one is followed by the next at once
    a_report_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=> o_res_valid)
        else $error("report burst broken before last");

    // single results always close their request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != ST_REPORT)) |-> o_res.last)
        else $error("single result without last");

    // the engine stays busy while a report burst is still going
    a_busy_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == ST_REPORT) && !o_res.last) |-> o_busy)
        else $error("report shown while idle");

    // unreached vertices report zero distance
    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == ST_REPORT) && !o_res.reached)
        |-> (o_res.distance == '0))
        else $error("unreached vertex with nonzero distance");

    // a clear transfer answers on the next cycle
    a_clear_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.req_type == REQ_CLEAR))
        |=> (o_res_valid && (o_res.status == ST_CLEARED)))
        else $error("clear not acknowledged");

endmodule

bind dijkstra_shortest_paths dsp_checker u_dsp_checker (.*);

FILE: verif/dijkstra_shortest_paths_tb.sv
// Self-checking bench for the shortest path engine: request driver, result monitor, graph model.
`timescale 1ns / 1ps

module dijkstra_shortest_paths_tb;
    import dsp_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    t_req              i_req;
    logic              o_res_valid;
    t_res              o_res;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [VCNT_W-1:0] i_cfg_data;

    dijkstra_shortest_paths i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // graph model
    bit                edge_map   [MAX_VERTICES][MAX_VERTICES];
    logic [15:0]       weight_map [MAX_VERTICES][MAX_VERTICES];
    logic [VCNT_W-1:0] vcount_model;

    t_req graph_requests[$];
    t_res engine_replies[$];
    int   mismatch_count;
    int   sender_idle_pct;
    bit   req_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("dijkstra_shortest_paths_tb NOT OK");
        $finish;
    end

    function automatic void queue_request(t_req r);
        graph_requests = {graph_requests, r};
    endfunction

    function automatic t_req take_request();
        t_req r;
        r = graph_requests[0];
        graph_requests.delete(0);
        return r;
    endfunction

    function automatic void add_reply(t_res r);
        engine_replies = {engine_replies, r};
    endfunction

    function automatic t_res take_reply();
        t_res r;
        r = engine_replies[0];
        engine_replies.delete(0);
        return r;
    endfunction

    function automatic int unsigned active_vertices();
        return (vcount_model > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_model);
    endfunction

    function automatic t_res lone_reply(logic [2:0] st);
        t_res r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic t_req req_of(logic [1:0] kind, int a, int b, int w, int s);
        t_req r;
        r.req_type      = kind;
        r.vertex_a      = VIDX_W'(a);
        r.vertex_b      = VIDX_W'(b);
        r.edge_weight   = 16'(w);
        r.source_vertex = VIDX_W'(s);
        return r;
    endfunction

    // update the graph model and queue the replies one request causes
    function automatic void solve_request(t_req r);
        int unsigned n, a, b, s, u, best, nd, round, i, j;
        bit          found;
        int unsigned tent_dist [MAX_VERTICES];
        bit          finite    [MAX_VERTICES];
        bit          settled   [MAX_VERTICES];
        t_res        rep;
        n = active_vertices();
        a = r.vertex_a;
        b = r.vertex_b;
        s = r.source_vertex;
        case (r.req_type)
            REQ_ADD: begin
                if (a >= n || b >= n || a == b) begin
                    add_reply(lone_reply(ST_REJECT));
                end else if (edge_map[a][b]) begin
                    add_reply(lone_reply(ST_DUP));
                end else begin
                    edge_map[a][b]   = 1'b1;
                    edge_map[b][a]   = 1'b1;
                    weight_map[a][b] = r.edge_weight;
                    weight_map[b][a] = r.edge_weight;
                    add_reply(lone_reply(ST_ADDED));
                end
            end
            REQ_CLEAR: begin
                foreach (edge_map[x, y]) edge_map[x][y] = 1'b0;
                add_reply(lone_reply(ST_CLEARED));
            end
            REQ_RUN: begin
                if (s >= n) begin
                    add_reply(lone_reply(ST_REJECT));
                end else begin
                    for (i = 0; i < MAX_VERTICES; i++) begin
                        finite[i]    = 1'b0;
                        settled[i]   = 1'b0;
                        tent_dist[i] = 0;
                    end
                    finite[s] = 1'b1;
                    for (round = 0; round < n; round++) begin
                        found = 1'b0;
                        u     = 0;
                        best  = 0;
                        // least finite distance, lowest index on ties
                        for (i = 0; i < n; i++) begin
                            if (!settled[i] && finite[i] && (!found || tent_dist[i] < best)) begin
                                found = 1'b1;
                                u     = i;
                                best  = tent_dist[i];
                            end
                        end
                        if (!found) break;
                        settled[u] = 1'b1;
                        for (j = 0; j < n; j++) begin
                            if (edge_map[u][j] && !settled[j]) begin
                                nd = best + weight_map[u][j];
                                if (nd > DIST_MAX) nd = DIST_MAX;
                                if (!finite[j] || nd < tent_dist[j]) begin
                                    finite[j]    = 1'b1;
                                    tent_dist[j] = nd;
                                end
                            end
                        end
                    end
                    for (i = 0; i < n; i++) begin
                        rep.status       = ST_REPORT;
                        rep.vertex_index = VIDX_W'(i);
                        rep.distance     = finite[i] ? DIST_W'(tent_dist[i]) : '0;
                        rep.reached      = finite[i];
                        rep.last         = (i == n - 1);
                        add_reply(rep);
                    end
                end
            end
            default: add_reply(lone_reply(ST_REJECT));
        endcase
    endfunction

    function automatic t_req random_request(int unsigned n);
        t_req        r;
        int unsigned k, a, b, lim;
        r.req_type      = REQ_ADD;
        r.vertex_a      = VIDX_W'($urandom);
        r.vertex_b      = VIDX_W'($urandom);
        r.source_vertex = VIDX_W'($urandom);
        case ($urandom_range(0, 2))
            0:       r.edge_weight = 16'($urandom_range(0, 20));
            1:       r.edge_weight = 16'($urandom);
            default: r.edge_weight = 16'hFFFF - 16'($urandom_range(0, 20));
        endcase
        k = $urandom_range(0, 99);
        if (k < 55 && n >= 2) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 2);
            if (b >= a) b++;
            r.vertex_a = VIDX_W'(a);
            r.vertex_b = VIDX_W'(b);
        end else if (k < 65 && n >= 2) begin
            // crowd a few low vertices so pairs repeat in both orders
            lim = (n < 3) ? n : 3;
            a   = $urandom_range(0, lim - 1);
            b   = (a + 1 + $urandom_range(0, lim - 2)) % lim;
            r.vertex_a = VIDX_W'(a);
            r.vertex_b = VIDX_W'(b);
        end else if (k < 72) begin
            if (n >= MAX_VERTICES || $urandom_range(0, 1))
                r.vertex_b = r.vertex_a;
            else if ($urandom_range(0, 1))
                r.vertex_b = VIDX_W'($urandom_range(n, 31));
            else
                r.vertex_a = VIDX_W'($urandom_range(n, 31));
        end else if (k < 88) begin
            r.req_type = REQ_RUN;
            if (n >= 1) r.source_vertex = VIDX_W'($urandom_range(0, n - 1));
        end else if (k < 92) begin
            r.req_type = REQ_RUN;
        end else if (k < 96) begin
            r.req_type = REQ_CLEAR;
        end else begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    task automatic queue_random(int count);
        repeat (count) queue_request(random_request(active_vertices()));
    endtask

    // hold until every request is taken and answered, then let the engine go idle
    task automatic settle_engine();
        while (graph_requests.size() != 0 || i_start || engine_replies.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [VCNT_W-1:0] value);
        settle_engine();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        vcount_model = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_start || req_taken)) begin
            req_taken = 1'b0;
            if (graph_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_start <= 1'b1;
                i_req   <= take_request();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // result monitor and request capture
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (engine_replies.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result status %0d", o_res.status));
                end else begin
                    want = take_reply();
                    if (o_res.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                o_res.status, want.status));
                    if (o_res.vertex_index !== want.vertex_index)
                        flag_mismatch($sformatf("vertex_index got %0d want %0d",
                                                o_res.vertex_index, want.vertex_index));
                    if (o_res.distance !== want.distance)
                        flag_mismatch($sformatf("distance of vertex %0d got %0d want %0d",
                                                want.vertex_index, o_res.distance,
                                                want.distance));
                    if (o_res.reached !== want.reached)
                        flag_mismatch($sformatf("reached of vertex %0d got %0d want %0d",
                                                want.vertex_index, o_res.reached,
                                                want.reached));
                    if (o_res.last !== want.last)
                        flag_mismatch($sformatf("last got %0d want %0d",
                                                o_res.last, want.last));
                end
            end
            if (i_start && !o_busy) begin
                solve_request(i_req);
                req_taken = 1'b1;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_req           = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        vcount_model    = VCOUNT_RESET;
        mismatch_count  = 0;
        req_taken       = 1'b0;
        sender_idle_pct = 15;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset vertex count
        queue_request(req_of(REQ_RUN,    0,  0, 0,      0));  // empty graph
        queue_request(req_of(REQ_ADD,    0, 31, 'hFFFF, 0));
        queue_request(req_of(REQ_ADD,   31,  0, 1,      0));  // duplicate, swapped
        queue_request(req_of(REQ_ADD,    0, 31, 7,      0));  // duplicate, same order
        queue_request(req_of(REQ_ADD,    7,  7, 9,      0));  // self loop
        queue_request(req_of(REQ_ADD,   31, 31, 'hFFFF, 31));
        queue_request(req_of(REQ_ADD,    1,  2, 0,      0));
        queue_request(req_of(REQ_ADD,    0,  1, 5,      0));
        queue_request(req_of(REQ_ADD,    3,  0, 5,      0));  // tie with vertex 1
        queue_request(req_of(REQ_ADD,    2, 31, 3,      0));
        queue_request(req_of(REQ_ADD,    0,  2, 100,    0));
        queue_request(req_of(REQ_UNUSED, 31, 31, 'hFFFF, 31));
        queue_request(req_of(REQ_UNUSED, 0,  0, 0,      0));
        queue_request(req_of(REQ_RUN,    0,  0, 0,      0));
        queue_request(req_of(REQ_RUN,    0,  0, 0,      31));
        queue_request(req_of(REQ_ADD,   30, 29, 'hAAAA, 0));
        queue_request(req_of(REQ_ADD,   29, 28, 'h5555, 0));
        queue_request(req_of(REQ_RUN,   31, 31, 'hFFFF, 30));
        queue_request(req_of(REQ_CLEAR,  0,  0, 0,      0));
        queue_request(req_of(REQ_ADD,    0, 31, 1,      0));  // gone after clear
        queue_request(req_of(REQ_RUN,    0,  0, 0,      0));
        queue_request(req_of(REQ_CLEAR, 31, 31, 'hFFFF, 31));

        set_vertex_count(VCNT_W'(0));
        queue_random(6);
        set_vertex_count(VCNT_W'(1));
        queue_random(6);
        set_vertex_count(VCNT_W'(5));
        queue_random(30);

        sender_idle_pct = 66;
        set_vertex_count(VCNT_W'(63));
        // heaviest chain through every vertex, then runs from both ends
        queue_request(req_of(REQ_CLEAR, 0, 0, 0, 0));
        for (int v = 0; v < MAX_VERTICES - 1; v++)
            queue_request(req_of(REQ_ADD, v, v + 1, 'hFFFF, 0));
        queue_request(req_of(REQ_RUN, 0, 0, 0, 0));
        queue_request(req_of(REQ_RUN, 0, 0, 0, 31));
        queue_random(8);
        set_vertex_count(VCNT_W'(8));
        queue_random(20);

        sender_idle_pct = 0;
        set_vertex_count(VCNT_W'($urandom_range(2, 12)));
        queue_random(30);
        set_vertex_count(VCNT_W'(32));
        queue_random(12);

        settle_engine();
        repeat (40) @(posedge i_clk);
        if (engine_replies.size() != 0)
            flag_mismatch($sformatf("%0d results never came", engine_replies.size()));
        if (mismatch_count == 0) begin
            $display("dijkstra_shortest_paths_tb OK");
        end else begin
            $display("dijkstra_shortest_paths_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: dijkstra_shortest_paths.f
sv/dsp_pkg.sv
sv/dijkstra_shortest_paths.sv
sv/dsp_checker.sv
verif/dijkstra_shortest_paths_tb.sv
